FILE: src/lkvc_pkg.sv
// lkvc_pkg: shared types and constants of the lru key/value cache.
// Used by the channel interfaces, the sequencer and the top level.
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CFG_W = 5;

  // operation codes carried in the cmd field
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic [CFG_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } kv_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] value;
  } res_t;

endpackage

FILE: src/lkvc_if.sv
// lkvc_req_if / lkvc_rsp_if: valid/ready channels of the cache.
// Depends on lkvc_pkg for the field widths.
`timescale 1ns / 1ps

interface lkvc_req_if;
  import lkvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [KEY_W-1:0] lookup_key;
  logic signed [VAL_W-1:0] write_value;

  modport source (output valid, output cmd, output lookup_key, output write_value,
                  input ready);
  modport sink   (input valid, input cmd, input lookup_key, input write_value,
                  output ready);
endinterface

interface lkvc_rsp_if;
  import lkvc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

FILE: src/lkvc_store.sv
// lkvc_store: slot memories of the cache, key/value and recency age.
// One write and one registered read per memory each cycle; uses lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_store #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                                  clk_i,
  input  logic [$clog2(ENTRIES)-1:0]            rd_addr_i,
  output lkvc_pkg::kv_t                         rd_kv_o,
  output logic [$clog2(ENTRIES)-1:0]            rd_age_o,
  input  logic                                  kv_we_i,
  input  logic [$clog2(ENTRIES)-1:0]            kv_waddr_i,
  input  lkvc_pkg::kv_t                         kv_wdata_i,
  input  logic                                  age_we_i,
  input  logic [$clog2(ENTRIES)-1:0]            age_waddr_i,
  input  logic [$clog2(ENTRIES)-1:0]            age_wdata_i
);
  import lkvc_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);

  kv_t            kv_mem  [ENTRIES];
  logic [AW-1:0]  age_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (kv_we_i) begin
      kv_mem[kv_waddr_i] <= kv_wdata_i;
    end
    rd_kv_o <= kv_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (age_we_i) begin
      age_mem[age_waddr_i] <= age_wdata_i;
    end
    rd_age_o <= age_mem[rd_addr_i];
  end

endmodule

FILE: src/lkvc_ctrl.sv
// lkvc_ctrl: sequencer of the cache; scans the slots through one compare unit,
// decides hit/evict/insert, then on a hit or an insert sweeps the recency ages. Uses lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_ctrl #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  lkvc_req_if.sink                              req_i,
  input  logic                                  at_limit_i,
  output logic [$clog2(ENTRIES+1)-1:0]          occ_o,
  output logic                                  res_valid_o,
  input  logic                                  res_ready_i,
  output lkvc_pkg::res_t                        res_o,
  output logic [$clog2(ENTRIES)-1:0]            rd_addr_o,
  input  lkvc_pkg::kv_t                         rd_kv_i,
  input  logic [$clog2(ENTRIES)-1:0]            rd_age_i,
  output logic                                  kv_we_o,
  output logic [$clog2(ENTRIES)-1:0]            kv_waddr_o,
  output lkvc_pkg::kv_t                         kv_wdata_o,
  output logic                                  age_we_o,
  output logic [$clog2(ENTRIES)-1:0]            age_waddr_o,
  output logic [$clog2(ENTRIES)-1:0]            age_wdata_o
);
  import lkvc_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    pv_q, pv_d;
  logic [AW-1:0]           pidx_q, pidx_d;
  logic [ENTRIES-1:0]      valid_q, valid_d;
  logic [CW-1:0]           occ_q, occ_d;

  logic                    cmd_q, cmd_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic signed [VAL_W-1:0] val_q, val_d;

  logic                    found_q, found_d;
  logic [AW-1:0]           hit_idx_q, hit_idx_d;
  logic [AW-1:0]           hit_age_q, hit_age_d;
  logic signed [VAL_W-1:0] hit_val_q, hit_val_d;
  logic                    free_q, free_d;
  logic [AW-1:0]           free_idx_q, free_idx_d;
  logic                    vic_q, vic_d;
  logic [AW-1:0]           vic_idx_q, vic_idx_d;
  logic [AW-1:0]           vic_age_q, vic_age_d;

  logic                    ins_mode_q, ins_mode_d;
  logic                    evict_q, evict_d;
  logic [AW-1:0]           tgt_q, tgt_d;
  res_t                    res_q, res_d;

  logic                    last;
  logic                    evict;
  logic                    ins_ok;
  logic [AW-1:0]           ins_slot;

  assign last        = (cnt_q == CW'(ENTRIES));
  assign req_i.ready = (state_q == ST_IDLE);
  assign occ_o       = occ_q;
  assign res_o       = res_q;
  assign rd_addr_o   = cnt_q[AW-1:0];

  // put of an absent key: evict the oldest when at the limit, fill the lowest free slot
  assign evict    = at_limit_i && vic_q;
  assign ins_ok   = evict || free_q;
  assign ins_slot = (evict && (!free_q || (vic_idx_q < free_idx_q))) ? vic_idx_q : free_idx_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pv_d       = 1'b0;
    pidx_d     = cnt_q[AW-1:0];
    valid_d    = valid_q;
    occ_d      = occ_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    val_d      = val_q;
    found_d    = found_q;
    hit_idx_d  = hit_idx_q;
    hit_age_d  = hit_age_q;
    hit_val_d  = hit_val_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    vic_d      = vic_q;
    vic_idx_d  = vic_idx_q;
    vic_age_d  = vic_age_q;
    ins_mode_d = ins_mode_q;
    evict_d    = evict_q;
    tgt_d      = tgt_q;
    res_d      = res_q;

    res_valid_o = 1'b0;
    kv_we_o     = 1'b0;
    kv_waddr_o  = tgt_q;
    kv_wdata_o  = '{key: key_q, value: val_q};
    age_we_o    = 1'b0;
    age_waddr_o = pidx_q;
    age_wdata_o = rd_age_i;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          cmd_d   = req_i.cmd;
          key_d   = req_i.lookup_key;
          val_d   = req_i.write_value;
          found_d = 1'b0;
          free_d  = 1'b0;
          vic_d   = 1'b0;
          cnt_d   = '0;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        pv_d = !last;
        if (!last) begin
          cnt_d = cnt_q + CW'(1);
        end
        // read data of the slot addressed in the previous cycle
        if (pv_q) begin
          if (valid_q[pidx_q] && (rd_kv_i.key == key_q) && !found_q) begin
            found_d   = 1'b1;
            hit_idx_d = pidx_q;
            hit_age_d = rd_age_i;
            hit_val_d = rd_kv_i.value;
          end
          if (!valid_q[pidx_q] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = pidx_q;
          end
          if (valid_q[pidx_q] && (!vic_q || (rd_age_i > vic_age_q))) begin
            vic_d     = 1'b1;
            vic_idx_d = pidx_q;
            vic_age_d = rd_age_i;
          end
        end
        if (last) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        cnt_d      = '0;
        res_d.hit  = found_q;
        res_d.value = found_q ? hit_val_q : MISS_VALUE;
        ins_mode_d = 1'b0;
        evict_d    = 1'b0;
        tgt_d      = hit_idx_q;
        if (cmd_q == CMD_GET) begin
          state_d = found_q ? ST_UPDATE : ST_RESULT;
        end else if (found_q) begin
          kv_we_o    = 1'b1;
          kv_waddr_o = hit_idx_q;
          state_d    = ST_UPDATE;
        end else begin
          ins_mode_d = 1'b1;
          evict_d    = evict;
          tgt_d      = ins_slot;
          kv_waddr_o = ins_slot;
          kv_we_o    = ins_ok;
          if (evict) begin
            valid_d[vic_idx_q] = 1'b0;
          end
          if (ins_ok) begin
            valid_d[ins_slot] = 1'b1;
          end
          if (evict && !ins_ok) begin
            occ_d = occ_q - CW'(1);
          end else if (!evict && ins_ok) begin
            occ_d = occ_q + CW'(1);
          end
          state_d = ins_ok ? ST_UPDATE : ST_IDLE;
        end
      end

      ST_UPDATE: begin
        pv_d = !last;
        if (!last) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (pv_q) begin
          age_we_o = valid_q[pidx_q];
          if (pidx_q == tgt_q) begin
            age_wdata_o = '0;
          end else if (ins_mode_q) begin
            // ages above the evicted one drop by one, then all age by one
            age_wdata_o = (evict_q && (rd_age_i > vic_age_q)) ? rd_age_i
                                                              : rd_age_i + AW'(1);
          end else if (rd_age_i < hit_age_q) begin
            age_wdata_o = rd_age_i + AW'(1);
          end
        end
        if (last) begin
          state_d = (cmd_q == CMD_GET) ? ST_RESULT : ST_IDLE;
        end
      end

      ST_RESULT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
      valid_q <= '0;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
      valid_q <= valid_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    val_q      <= val_d;
    found_q    <= found_d;
    hit_idx_q  <= hit_idx_d;
    hit_age_q  <= hit_age_d;
    hit_val_q  <= hit_val_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    vic_q      <= vic_d;
    vic_idx_q  <= vic_idx_d;
    vic_age_q  <= vic_age_d;
    ins_mode_q <= ins_mode_d;
    evict_q    <= evict_d;
    tgt_q      <= tgt_d;
    res_q      <= res_d;
  end

endmodule

FILE: src/lru_key_value_cache_unit.sv
// lru_key_value_cache_unit: fully associative key/value cache, lru replacement.
// A get scans every slot for the key, then on a hit sweeps the recency ages, before its result goes valid;
// a put gives no result. The next beat is accepted only once the sequencer is idle again, the pace
// set by the one-slot-per-cycle read port (key scan, then age sweep).
// Reset clears all valid bits and the occupancy at once; the limit resets to 16.
// Depends on lkvc_pkg, lkvc_req_if/lkvc_rsp_if, lkvc_store and lkvc_ctrl.
`timescale 1ns / 1ps

module lru_key_value_cache_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lkvc_pkg::CFG_W-1:0]    cfg_wdata_i,
  lkvc_req_if.sink                      req_i,
  lkvc_rsp_if.source                    rsp_o
);
  import lkvc_pkg::*;

  localparam int unsigned AW   = $clog2(ENTRIES);
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0] cap_q;
  logic [CMPW-1:0]  cap_ext;
  logic [CMPW-1:0]  eff_lim;
  logic [CW-1:0]    occ;
  logic             at_limit;

  logic             res_valid;
  logic             res_ready;
  res_t             res;

  logic             out_valid_q;
  res_t             out_q;

  logic [AW-1:0]    rd_addr;
  kv_t              rd_kv;
  logic [AW-1:0]    rd_age;
  logic             kv_we;
  logic [AW-1:0]    kv_waddr;
  kv_t              kv_wdata;
  logic             age_we;
  logic [AW-1:0]    age_waddr;
  logic [AW-1:0]    age_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // zero acts as one, anything above the table size saturates
  assign cap_ext  = CMPW'(cap_q);
  assign eff_lim  = (cap_q == '0) ? CMPW'(1) :
                    ((cap_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_ext);
  assign at_limit = (CMPW'(occ) >= eff_lim);

  lkvc_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk_i       (clk_i),
    .rd_addr_i   (rd_addr),
    .rd_kv_o     (rd_kv),
    .rd_age_o    (rd_age),
    .kv_we_i     (kv_we),
    .kv_waddr_i  (kv_waddr),
    .kv_wdata_i  (kv_wdata),
    .age_we_i    (age_we),
    .age_waddr_i (age_waddr),
    .age_wdata_i (age_wdata)
  );

  lkvc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .at_limit_i  (at_limit),
    .occ_o       (occ),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_addr_o   (rd_addr),
    .rd_kv_i     (rd_kv),
    .rd_age_i    (rd_age),
    .kv_we_o     (kv_we),
    .kv_waddr_o  (kv_waddr),
    .kv_wdata_o  (kv_wdata),
    .age_we_o    (age_we),
    .age_waddr_o (age_waddr),
    .age_wdata_o (age_wdata)
  );

  // output register: a finished beat waits here while the next item runs
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hit        = out_q.hit;
  assign rsp_o.read_value = out_q.value;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("cache ready again right after accepting a beat");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= CW'(ENTRIES))
    else $error("occupancy above table size");

  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.hit |-> rsp_o.read_value == MISS_VALUE)
    else $error("miss beat without all-ones value");
`endif

endmodule
